// File: sv/fgp_pkg.sv
// ----------------------------------------------------------------------------
// fgp_pkg
// Shared types, function codes and stream layout of the glyph plotter.
// ----------------------------------------------------------------------------
package fgp_pkg;

    // Default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 32;

    // Printable character range
    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST  = 8'd126;

    // Function codes
    localparam logic [2:0] FN_CLEAR     = 3'd0;
    localparam logic [2:0] FN_PIXEL     = 3'd1;
    localparam logic [2:0] FN_GLYPH_XY  = 3'd2;
    localparam logic [2:0] FN_GLYPH_CUR = 3'd3;
    localparam logic [2:0] FN_READ      = 3'd4;
    localparam logic [2:0] FN_MARK      = 3'd5;

    // Memory address source
    localparam logic [1:0] ASEL_CLR   = 2'd0;
    localparam logic [1:0] ASEL_BIDX  = 2'd1;
    localparam logic [1:0] ASEL_PIX   = 2'd2;
    localparam logic [1:0] ASEL_GLYPH = 2'd3;

    // Stream widths
    localparam int IN_TDATA_W  = 168;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 16;

    // Input tdata field offsets
    localparam int OFS_POS_X     = 0;
    localparam int OFS_POS_Y     = 9;
    localparam int OFS_PIXEL_ON  = 18;
    localparam int OFS_CHAR_CODE = 19;
    localparam int OFS_GLYPH_LO  = 27;
    localparam int OFS_GLYPH_HI  = 91;
    localparam int OFS_BYTE_IDX  = 155;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       clr_init;
        logic       clr_adv;
        logic       cur_upd;
        logic       step_adv;
        logic       wr;
        logic [1:0] asel;
        logic       rb_cap;
        logic       dirty_set;
        logic       dirty_clr;
        logic       res_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       pix_in;
        logic       glyph_go;
        logic       clr_last;
        logic       step_last;
        logic       out_free;
    } t_status;

endpackage

// File: sv/fgp_ram.sv
// ----------------------------------------------------------------------------
// fgp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/fgp_ctrl.sv
// ----------------------------------------------------------------------------
// fgp_ctrl
// Controller state machine: sequences clear sweeps, pixel and glyph
// read-modify-write steps, byte reads and result hand-off.
// ----------------------------------------------------------------------------
module fgp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fgp_pkg::t_status i_status,
    output fgp_pkg::t_cmd   o_cmd
);

    import fgp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_GRD    = 3'd3;
    localparam logic [2:0] ST_GWR    = 3'd4;
    localparam logic [2:0] ST_PWR    = 3'd5;
    localparam logic [2:0] ST_RDAT   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_clr_rep, n_clr_rep;
    t_cmd       w_cmd;
    logic       w_ready;

    // Next state and command decode
    always_comb begin
        n_state   = r_state;
        n_clr_rep = r_clr_rep;
        w_cmd     = '0;
        w_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_status.func)
                    FN_CLEAR: begin
                        w_cmd.clr_init  = 1'b1;
                        w_cmd.dirty_set = 1'b1;
                        n_clr_rep       = 1'b1;
                        n_state         = ST_CLEAR;
                    end
                    FN_PIXEL: begin
                        w_cmd.asel = ASEL_PIX;
                        if (i_status.pix_in) begin
                            w_cmd.dirty_set = 1'b1;
                            n_state         = ST_PWR;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    FN_GLYPH_XY, FN_GLYPH_CUR: begin
                        w_cmd.cur_upd   = 1'b1;
                        w_cmd.dirty_set = 1'b1;
                        n_state         = i_status.glyph_go ? ST_GRD : ST_DONE;
                    end
                    FN_READ: begin
                        w_cmd.asel = ASEL_BIDX;
                        n_state    = ST_RDAT;
                    end
                    FN_MARK: begin
                        w_cmd.dirty_clr = 1'b1;
                        n_state         = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_CLEAR: begin
                w_cmd.asel    = ASEL_CLR;
                w_cmd.wr      = 1'b1;
                w_cmd.clr_adv = 1'b1;
                if (i_status.clr_last) begin
                    n_state = r_clr_rep ? ST_DONE : ST_IDLE;
                end
            end
            ST_GRD: begin
                w_cmd.asel = ASEL_GLYPH;
                n_state    = ST_GWR;
            end
            ST_GWR: begin
                w_cmd.asel     = ASEL_GLYPH;
                w_cmd.wr       = 1'b1;
                w_cmd.step_adv = 1'b1;
                n_state        = i_status.step_last ? ST_DONE : ST_GRD;
            end
            ST_PWR: begin
                w_cmd.asel = ASEL_PIX;
                w_cmd.wr   = 1'b1;
                n_state    = ST_DONE;
            end
            ST_RDAT: begin
                w_cmd.rb_cap = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    w_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers; reset starts with a silent clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_rep <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_rep <= n_clr_rep;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = w_ready;

endmodule

// File: sv/fgp_datapath.sv
// ----------------------------------------------------------------------------
// fgp_datapath
// Transaction capture, cursor, glyph column/page stepping, address and
// write-data generation, frame store and output register.
// ----------------------------------------------------------------------------
module fgp_datapath #(
    parameter int SCREEN_WIDTH  = fgp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = fgp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fgp_pkg::t_cmd                    i_cmd,
    output fgp_pkg::t_status                 o_status,
    input  logic [fgp_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  logic [fgp_pkg::IN_TUSER_W-1:0]   i_in_user,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [fgp_pkg::OUT_TDATA_W-1:0]  o_out_data
);

    import fgp_pkg::*;

    localparam int FB_PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FB_BYTES  = SCREEN_WIDTH * FB_PAGES;
    localparam int ADDR_W    = $clog2(FB_BYTES);
    localparam int LAST_ROWS = SCREEN_HEIGHT - 8 * (FB_PAGES - 1);
    localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);
    localparam logic signed [10:0] SW_S11  = 11'(SCREEN_WIDTH);
    localparam logic signed [10:0] SH_S11  = 11'(SCREEN_HEIGHT);
    localparam logic signed [9:0]  SW_S10  = 10'(SCREEN_WIDTH);
    localparam logic signed [6:0]  PG_S7   = 7'(FB_PAGES);
    localparam logic signed [6:0]  LPG_S7  = 7'(FB_PAGES - 1);
    localparam logic [11:0]        SW_U12  = 12'(SCREEN_WIDTH);
    localparam logic [11:0]        FBB_U12 = 12'(FB_BYTES);
    localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(FB_BYTES - 1);

    // Captured transaction
    logic [2:0]  r_func;
    logic [8:0]  r_px;
    logic [8:0]  r_py;
    logic        r_on;
    logic [7:0]  r_code;
    logic        r_kind;
    logic [63:0] r_lo;
    logic [63:0] r_hi;
    logic [8:0]  r_bidx;

    // Persistent state
    logic [9:0]  r_cur_col;
    logic [8:0]  r_cur_row;
    logic        r_dirty;
    logic [ADDR_W-1:0] r_clr_addr;

    // Glyph walk
    logic [9:0]  r_gx;
    logic [8:0]  r_gy;
    logic [2:0]  r_col;
    logic [1:0]  r_pg;

    // Result
    logic [7:0]  r_rbyte;
    logic        r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    // Capture on load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_user[2:0];
            r_kind <= i_in_user[3];
            r_px   <= i_in_data[OFS_POS_X +: 9];
            r_py   <= i_in_data[OFS_POS_Y +: 9];
            r_on   <= i_in_data[OFS_PIXEL_ON];
            r_code <= i_in_data[OFS_CHAR_CODE +: 8];
            r_lo   <= i_in_data[OFS_GLYPH_LO +: 64];
            r_hi   <= i_in_data[OFS_GLYPH_HI +: 64];
            r_bidx <= i_in_data[OFS_BYTE_IDX +: 9];
        end
    end

    // Pixel range check and address
    logic signed [10:0] w_px11, w_py11;
    logic               w_pix_in;
    logic [11:0]        w_pix_lin;
    logic [7:0]         w_pix_bit;

    assign w_px11    = {{2{r_px[8]}}, r_px};
    assign w_py11    = {{2{r_py[8]}}, r_py};
    assign w_pix_in  = (w_px11 >= 11'sd0) && (w_px11 < SW_S11) &&
                       (w_py11 >= 11'sd0) && (w_py11 < SH_S11);
    assign w_pix_lin = {4'b0, r_px[7:0]} + {9'b0, r_py[5:3]} * SW_U12;
    assign w_pix_bit = 8'd1 << r_py[2:0];

    // Cursor selection and draw decision
    logic signed [9:0] w_eff_col;
    logic [8:0]        w_eff_row;
    logic              w_col_ok;
    logic              w_printable;
    logic [9:0]        w_adv;

    assign w_eff_col   = (r_func == FN_GLYPH_XY) ? {r_px[8], r_px} : r_cur_col;
    assign w_eff_row   = (r_func == FN_GLYPH_XY) ? r_py : r_cur_row;
    assign w_col_ok    = w_eff_col < SW_S10;
    assign w_printable = (r_code >= CODE_FIRST) && (r_code <= CODE_LAST);
    assign w_adv       = r_kind ? 10'd9 : 10'd6;

    // Glyph step position
    logic signed [10:0] w_gx11;
    logic signed [6:0]  w_gpg;
    logic               w_g_valid;
    logic [11:0]        w_g_lin;
    logic [2:0]         w_col_last;
    logic [1:0]         w_pg_last;
    logic               w_step_last;

    assign w_gx11      = {r_gx[9], r_gx} + {8'b0, r_col};
    assign w_gpg       = {r_gy[8], r_gy[8:3]} + {5'b0, r_pg};
    assign w_g_valid   = (w_gx11 >= 11'sd0) && (w_gx11 < SW_S11) &&
                         (w_gpg >= 7'sd0) && (w_gpg < PG_S7);
    assign w_g_lin     = {4'b0, w_gx11[7:0]} + {9'b0, w_gpg[2:0]} * SW_U12;
    assign w_col_last  = r_kind ? 3'd7 : 3'd4;
    assign w_pg_last   = r_kind ? 2'd2 : 2'd1;
    assign w_step_last = (r_col == w_col_last) && (r_pg == w_pg_last);

    // Column pattern: one bit per glyph row, top row in bit 0
    logic [7:0]  w_gbytes [16];
    logic [15:0] w_pat;
    logic [23:0] w_shift;
    logic [7:0]  w_gbyte;
    logic [7:0]  w_hmask;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_gbytes[i]     = r_lo[8*i +: 8];
            w_gbytes[i + 8] = r_hi[8*i +: 8];
        end
        if (r_kind) begin
            for (int r = 0; r < 16; r++) begin
                w_pat[r] = w_gbytes[r][3'd7 - r_col];
            end
        end else begin
            w_pat = {8'b0, w_gbytes[{1'b0, r_col}]};
        end
    end

    assign w_shift = {8'b0, w_pat} << r_gy[2:0];

    // Pick the page slice of the shifted column
    always_comb begin
        case (r_pg)
            2'd0:    w_gbyte = w_shift[7:0];
            2'd1:    w_gbyte = w_shift[15:8];
            2'd2:    w_gbyte = w_shift[23:16];
            default: w_gbyte = 8'd0;
        endcase
    end

    assign w_hmask = (w_gpg == LPG_S7) ? LAST_MASK : 8'hFF;

    // Frame store access
    logic [ADDR_W-1:0] w_addr;
    logic [7:0]        w_rdata;
    logic [7:0]        w_wdata;
    logic              w_we;
    logic              w_bidx_ok;

    always_comb begin
        case (i_cmd.asel)
            ASEL_CLR: begin
                w_addr  = r_clr_addr;
                w_wdata = 8'd0;
            end
            ASEL_BIDX: begin
                w_addr  = ADDR_W'(r_bidx);
                w_wdata = 8'd0;
            end
            ASEL_PIX: begin
                w_addr  = ADDR_W'(w_pix_lin);
                w_wdata = r_on ? (w_rdata | w_pix_bit) : (w_rdata & ~w_pix_bit);
            end
            ASEL_GLYPH: begin
                w_addr  = ADDR_W'(w_g_lin);
                w_wdata = w_rdata | (w_gbyte & w_hmask);
            end
            default: begin
                w_addr  = r_clr_addr;
                w_wdata = 8'd0;
            end
        endcase
    end

    assign w_we      = i_cmd.wr && ((i_cmd.asel != ASEL_GLYPH) || w_g_valid);
    assign w_bidx_ok = {3'b0, r_bidx} < FBB_U12;

    fgp_ram #(
        .WIDTH (8),
        .DEPTH (FB_BYTES)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Cursor, dirty flag and clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_dirty    <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.cur_upd) begin
                r_cur_row <= w_eff_row;
                r_cur_col <= w_col_ok ? (w_eff_col + w_adv) : w_eff_col;
            end
            if (i_cmd.dirty_set) begin
                r_dirty <= 1'b1;
            end else if (i_cmd.dirty_clr) begin
                r_dirty <= 1'b0;
            end
            if (i_cmd.clr_init) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_adv) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Glyph walk: pages inner, columns outer
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_upd) begin
            r_gx  <= w_eff_col;
            r_gy  <= w_eff_row;
            r_col <= '0;
            r_pg  <= '0;
        end else if (i_cmd.step_adv) begin
            if (r_pg == w_pg_last) begin
                r_pg  <= '0;
                r_col <= r_col + 1'b1;
            end else begin
                r_pg <= r_pg + 1'b1;
            end
        end
    end

    // Read byte capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rbyte <= 8'd0;
        end else if (i_cmd.rb_cap) begin
            r_rbyte <= w_bidx_ok ? w_rdata : 8'd0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_odata <= {7'b0, r_dirty, r_rbyte};
        end
    end

    // Status to controller
    assign o_status.func      = r_func;
    assign o_status.pix_in    = w_pix_in;
    assign o_status.glyph_go  = w_col_ok && w_printable;
    assign o_status.clr_last  = (r_clr_addr == CLR_LAST);
    assign o_status.step_last = w_step_last;
    assign o_status.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

// File: sv/framebuffer_glyph_plotter_unit.sv
// ----------------------------------------------------------------------------
// framebuffer_glyph_plotter_unit
// Page-organized monochrome framebuffer with pixel set/clear, glyph plotting
// at a position or at a text cursor, byte readout and a modified flag.
//
// Input stream (s_axis): one transaction per operation; tuser carries the
// function code and font kind, tdata the coordinates, glyph and index.
// Output stream (m_axis): exactly one transaction per input transaction,
// carrying the read byte (zero unless a read) and the modified flag.
// Operations run one at a time, with the frame store behind a single
// registered-read RAM port; steps from accept to result valid:
//   mark sent / unused codes / skipped draws / off-screen pixels: decode only
//   on-screen pixel: decode with read, then write; byte read: decode, capture
//   glyph: decode, then per touched column and page a read step and a write
//   step, the write suppressed where the byte falls off screen
//   clear: decode, then one byte written per cycle over the whole store
// After reset the block sweeps all FB_BYTES bytes of the store to zero
// (512 at the default geometry) before it takes the first transaction.
// A finished result sits in an output register; the next transaction is
// accepted while it waits, and the following result holds until taken.
// ----------------------------------------------------------------------------
module framebuffer_glyph_plotter_unit #(
    parameter int SCREEN_WIDTH  = fgp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = fgp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pos_x[8:0], pos_y[17:9], pixel_on[18], char_code[26:19],
    // glyph_low[90:27], glyph_high[154:91], byte_index[163:155], zero pad
    input  logic [fgp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func[2:0], font_kind[3]
    input  logic [fgp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_byte[7:0], modified[8], zero pad
    output logic [fgp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import fgp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    fgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fgp_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
